[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_CLKRST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLKRST(lbl, clk, rst_n, prop)
`define ASSERT_CLK(lbl, clk, prop)
`endif

`endif

[rtl/nfrc_pkg.sv]
// ----------------------------------------------------------------------------
// nfrc_pkg
// Types and constants for the LF-delimited frame reader and checker.
// ----------------------------------------------------------------------------
package nfrc_pkg;

  localparam int unsigned LEN_W   = 17;
  localparam int unsigned BYTE_W  = 8;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_EOS  = 2'd1,
    KIND_ERR  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_PROTO = 2'd1,
    ST_IO    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    TC_LEAD = 2'd0,
    TC_TEXT = 2'd1,
    TC_NOT  = 2'd2
  } tclass_t;

  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [BYTE_W-1:0] PRINT_LO  = 8'h20;
  localparam logic [BYTE_W-1:0] PRINT_HI  = 8'h7E;

  localparam logic [LEN_W-1:0] LIMIT_RESET = 17'h10000;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              frame_end;
    status_t           status;
    logic              plain_text_flag;
    logic              eos_clean;
    logic [LEN_W-1:0]  frame_length;
  } result_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

  function automatic logic is_printable(logic [BYTE_W-1:0] b);
    is_printable = (b == CH_TAB) || ((b >= PRINT_LO) && (b <= PRINT_HI));
  endfunction

endpackage

[rtl/nfrc_in_stage.sv]
// ----------------------------------------------------------------------------
// nfrc_in_stage
// Input register: holds one event until the checker core consumes it.
// ----------------------------------------------------------------------------
module nfrc_in_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [nfrc_pkg::BYTE_W-1:0]   in_byte,
  input  logic [1:0]                    in_kind,
  input  logic                          take,
  output logic                          s1_valid,
  output logic [nfrc_pkg::BYTE_W-1:0]   s1_byte,
  output logic [1:0]                    s1_kind
);

  logic                        valid_r, valid_nxt;
  logic [nfrc_pkg::BYTE_W-1:0] byte_r;
  logic [1:0]                  kind_r;
  logic                        load;

  assign in_tready = !valid_r || take;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_byte;
      kind_r <= in_kind;
    end
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;
  assign s1_kind  = kind_r;

endmodule

[rtl/nfrc_core.sv]
// ----------------------------------------------------------------------------
// nfrc_core
// Framing state, text classifier and frame-end status for one event.
// ----------------------------------------------------------------------------
module nfrc_core #(
  parameter int MAX_FRAME = 65536
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [nfrc_pkg::LEN_W-1:0]    frame_limit,
  input  logic                          s1_valid,
  input  logic [nfrc_pkg::BYTE_W-1:0]   s1_byte,
  input  logic [1:0]                    s1_kind,
  input  logic                          out_rdy,
  output logic                          take,
  output nfrc_pkg::hs_t                 res_hs,
  output nfrc_pkg::result_t             res
);

  localparam logic [nfrc_pkg::LEN_W-1:0] LIMIT_CAP =
    (MAX_FRAME >= 131071) ? 17'h1FFFF : 17'(MAX_FRAME);

  logic [nfrc_pkg::LEN_W-1:0] cnt_r, cnt_nxt;
  nfrc_pkg::tclass_t          tc_r, tc_nxt;
  logic                       disc_r, disc_nxt;
  logic                       res_vld;
  logic                       limit_bad;
  nfrc_pkg::tclass_t          tc_step;

  assign limit_bad = (frame_limit == '0) || (frame_limit > LIMIT_CAP);

  always_comb begin
    tc_step = tc_r;
    case (tc_r)
      nfrc_pkg::TC_LEAD: begin
        if ((s1_byte == nfrc_pkg::CH_SPACE) || (s1_byte == nfrc_pkg::CH_TAB)) begin
          tc_step = nfrc_pkg::TC_LEAD;
        end else if ((s1_byte == nfrc_pkg::CH_LBRACE) ||
                     !nfrc_pkg::is_printable(s1_byte)) begin
          tc_step = nfrc_pkg::TC_NOT;
        end else begin
          tc_step = nfrc_pkg::TC_TEXT;
        end
      end
      nfrc_pkg::TC_TEXT: begin
        if (!nfrc_pkg::is_printable(s1_byte)) begin
          tc_step = nfrc_pkg::TC_NOT;
        end
      end
      default: tc_step = nfrc_pkg::TC_NOT;
    endcase
  end

  always_comb begin
    res      = '0;
    res_vld  = 1'b0;
    cnt_nxt  = cnt_r;
    tc_nxt   = tc_r;
    disc_nxt = disc_r;
    if (s1_valid && (s1_kind != nfrc_pkg::KIND_NONE)) begin
      if (limit_bad) begin
        res_vld        = 1'b1;
        res.frame_end  = 1'b1;
        res.status     = nfrc_pkg::ST_PROTO;
        cnt_nxt        = '0;
        tc_nxt         = nfrc_pkg::TC_LEAD;
        disc_nxt       = 1'b0;
      end else begin
        // frame-end defaults; overridden for plain payload bytes
        res.frame_end       = 1'b1;
        res.plain_text_flag = (tc_r == nfrc_pkg::TC_TEXT);
        res.frame_length    = cnt_r;
        unique case (nfrc_pkg::kind_t'(s1_kind))
          nfrc_pkg::KIND_ERR: begin
            res_vld    = 1'b1;
            res.status = nfrc_pkg::ST_IO;
            disc_nxt   = 1'b0;
          end
          nfrc_pkg::KIND_EOS: begin
            res_vld = 1'b1;
            if (disc_r || (cnt_r == '0)) begin
              res.status    = nfrc_pkg::ST_OK;
              res.eos_clean = 1'b1;
            end else begin
              res.status = nfrc_pkg::ST_PROTO;
            end
            disc_nxt = 1'b0;
          end
          nfrc_pkg::KIND_DATA: begin
            if (disc_r) begin
              if (s1_byte == nfrc_pkg::CH_LF) begin
                disc_nxt = 1'b0;
              end
            end else if (s1_byte == nfrc_pkg::CH_LF) begin
              res_vld    = 1'b1;
              res.status = ((cnt_r == '0) || (tc_r == nfrc_pkg::TC_TEXT)) ?
                           nfrc_pkg::ST_PROTO : nfrc_pkg::ST_OK;
            end else if ((s1_byte == nfrc_pkg::CH_CR) || (cnt_r >= frame_limit)) begin
              res_vld    = 1'b1;
              res.status = nfrc_pkg::ST_PROTO;
              disc_nxt   = 1'b1;
            end else begin
              res_vld             = 1'b1;
              res.frame_end       = 1'b0;
              res.plain_text_flag = 1'b0;
              res.data_byte       = s1_byte;
              res.frame_length    = cnt_r + 17'd1;
            end
          end
          default: res_vld = 1'b0;
        endcase
        if (res_vld && res.frame_end) begin
          cnt_nxt = '0;
          tc_nxt  = nfrc_pkg::TC_LEAD;
        end else if (res_vld) begin
          cnt_nxt = cnt_r + 17'd1;
          tc_nxt  = tc_step;
        end
      end
    end
  end

  assign take   = s1_valid && (!res_vld || out_rdy);
  assign res_hs = {res_vld && take, out_rdy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      tc_r   <= nfrc_pkg::TC_LEAD;
      disc_r <= 1'b0;
    end else if (take) begin
      cnt_r  <= cnt_nxt;
      tc_r   <= tc_nxt;
      disc_r <= disc_nxt;
    end
  end

endmodule

[rtl/nfrc_out_stage.sv]
// ----------------------------------------------------------------------------
// nfrc_out_stage
// Result register: holds one result until the downstream transfer.
// ----------------------------------------------------------------------------
module nfrc_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  nfrc_pkg::hs_t     res_hs,
  input  nfrc_pkg::result_t res,
  output logic              out_rdy,
  output logic              out_tvalid,
  input  logic              out_tready,
  output nfrc_pkg::result_t out_res
);

  logic              valid_r, valid_nxt;
  nfrc_pkg::result_t res_r;

  assign out_rdy = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (res_hs.valid && res_hs.ready) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_hs.valid && res_hs.ready) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_res    = res_r;

endmodule

[rtl/newline_frame_reader_checker_unit.sv]
// Order: an input transfer loads the input register, the checker core works on
// it, and its result is loaded into the result register that drives out_*.
// Throughput: one event per cycle; the input register, the checker core and
// the result register each move one item per clock, stalls propagate back.
// Reset (rst_n low, synchronous): both stages empty, byte count and text
// classifier cleared, not discarding, frame_limit back to 65536.
// ----------------------------------------------------------------------------
// newline_frame_reader_checker_unit
// Splits a byte stream into LF-delimited frames and checks each frame.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module newline_frame_reader_checker_unit #(
  parameter int MAX_FRAME = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,   // frame_limit
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] byte_in
  input  logic [1:0]  in_tuser,    // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [7:0] data_byte, [24:8] frame_length, rest 0
  output logic        out_tlast,   // frame_end
  output logic [3:0]  out_tuser    // [1:0] status, [2] plain_text_flag, [3] eos_clean
);

  logic [nfrc_pkg::LEN_W-1:0]  frame_limit_r;
  logic                        s1_valid;
  logic [nfrc_pkg::BYTE_W-1:0] s1_byte;
  logic [1:0]                  s1_kind;
  logic                        take;
  logic                        out_rdy;
  nfrc_pkg::hs_t               res_hs;
  nfrc_pkg::result_t           res;
  nfrc_pkg::result_t           out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_limit_r <= nfrc_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      frame_limit_r <= cfg_wdata;
    end
  end

  nfrc_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .in_kind   (in_tuser),
    .take      (take),
    .s1_valid  (s1_valid),
    .s1_byte   (s1_byte),
    .s1_kind   (s1_kind)
  );

  nfrc_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_limit (frame_limit_r),
    .s1_valid    (s1_valid),
    .s1_byte     (s1_byte),
    .s1_kind     (s1_kind),
    .out_rdy     (out_rdy),
    .take        (take),
    .res_hs      (res_hs),
    .res         (res)
  );

  nfrc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_hs     (res_hs),
    .res        (res),
    .out_rdy    (out_rdy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {7'd0, out_res.frame_length, out_res.data_byte};
  assign out_tlast = out_res.frame_end;
  assign out_tuser = {out_res.eos_clean, out_res.plain_text_flag, out_res.status};

  `ASSERT_CLK(a_rst_empty, clk, !rst_n |=> !out_tvalid)
  `ASSERT_CLKRST(a_data_no_status, clk, rst_n, (out_tvalid && !out_tlast) |-> (out_tuser == 4'd0))
  `ASSERT_CLKRST(a_data_len_nz, clk, rst_n, (out_tvalid && !out_tlast) |-> (out_tdata[24:8] != 0))
  `ASSERT_CLKRST(a_no_load_when_full, clk, rst_n, (out_tvalid && !out_tready) |-> !res_hs.valid)

endmodule

[tb/newline_frame_reader_checker_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// newline_frame_reader_checker_unit_test
// Streams bytes, end-of-stream and read-error events through the LF frame
// checker. Every result transfer is checked against a frame predictor.
// Runs several frame_limit settings (invalid ones too) and idle/stall mixes.
// ----------------------------------------------------------------------------
module newline_frame_reader_checker_unit_test;

  localparam int          MAX_FRAME_LEN = 65536;
  localparam int          QUIET_LIMIT   = 5000;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          FINAL_LIMIT   = 48;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [16:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic [3:0]  out_tuser;

  newline_frame_reader_checker_unit #(
    .MAX_FRAME (MAX_FRAME_LEN)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  class frame_scoreboard;
    logic [16:0]        limit;
    logic [16:0]        count;
    nfrc_pkg::tclass_t  tclass;
    bit                 discarding;
    nfrc_pkg::result_t  frame_q[$];
    int unsigned        errors;

    function new();
      limit      = nfrc_pkg::LIMIT_RESET;
      count      = '0;
      tclass     = nfrc_pkg::TC_LEAD;
      discarding = 1'b0;
      errors     = 0;
    endfunction

    function void set_limit(logic [16:0] v);
      limit = v;
    endfunction

    function int pending();
      return frame_q.size();
    endfunction

    function void close_frame(nfrc_pkg::status_t st, bit eof, bit drop_rest);
      nfrc_pkg::result_t r;
      r                 = '0;
      r.frame_end       = 1'b1;
      r.status          = st;
      r.plain_text_flag = (tclass == nfrc_pkg::TC_TEXT);
      r.eos_clean       = eof;
      r.frame_length    = count;
      frame_q.push_back(r);
      count      = '0;
      tclass     = nfrc_pkg::TC_LEAD;
      discarding = drop_rest;
    endfunction

    function void note_input(logic [1:0] k, logic [7:0] b);
      nfrc_pkg::result_t r;
      bit                printable;
      if (k == nfrc_pkg::KIND_NONE) return;
      if (limit == 0 || limit > MAX_FRAME_LEN) begin
        count      = '0;
        tclass     = nfrc_pkg::TC_LEAD;
        discarding = 1'b0;
        r           = '0;
        r.frame_end = 1'b1;
        r.status    = nfrc_pkg::ST_PROTO;
        frame_q.push_back(r);
        return;
      end
      if (k == nfrc_pkg::KIND_ERR) begin
        close_frame(nfrc_pkg::ST_IO, 1'b0, 1'b0);
        return;
      end
      if (k == nfrc_pkg::KIND_EOS) begin
        if (discarding || count == 0) close_frame(nfrc_pkg::ST_OK, 1'b1, 1'b0);
        else close_frame(nfrc_pkg::ST_PROTO, 1'b0, 1'b0);
        return;
      end
      if (discarding) begin
        if (b == nfrc_pkg::CH_LF) discarding = 1'b0;
        return;
      end
      if (b == nfrc_pkg::CH_LF) begin
        if (count == 0 || tclass == nfrc_pkg::TC_TEXT)
          close_frame(nfrc_pkg::ST_PROTO, 1'b0, 1'b0);
        else
          close_frame(nfrc_pkg::ST_OK, 1'b0, 1'b0);
        return;
      end
      if (b == nfrc_pkg::CH_CR || count >= limit) begin
        close_frame(nfrc_pkg::ST_PROTO, 1'b0, 1'b1);
        return;
      end
      count++;
      printable = (b == nfrc_pkg::CH_TAB) ||
                  (b >= nfrc_pkg::PRINT_LO && b <= nfrc_pkg::PRINT_HI);
      case (tclass)
        nfrc_pkg::TC_LEAD: begin
          if (b != nfrc_pkg::CH_SPACE && b != nfrc_pkg::CH_TAB)
            tclass = (b == nfrc_pkg::CH_LBRACE || !printable) ?
                     nfrc_pkg::TC_NOT : nfrc_pkg::TC_TEXT;
        end
        nfrc_pkg::TC_TEXT: begin
          if (!printable) tclass = nfrc_pkg::TC_NOT;
        end
        default: tclass = nfrc_pkg::TC_NOT;
      endcase
      r              = '0;
      r.data_byte    = b;
      r.frame_length = count;
      frame_q.push_back(r);
    endfunction

    function void compare(string name, int unsigned want_v, int unsigned got_v);
      if (want_v != got_v) begin
        $error("%s: expected %0d, got %0d", name, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(nfrc_pkg::result_t got);
      nfrc_pkg::result_t want;
      if (frame_q.size() == 0) begin
        $error("result transfer with nothing outstanding");
        errors++;
        return;
      end
      want = frame_q.pop_front();
      compare("data_byte", want.data_byte, got.data_byte);
      compare("frame_end", want.frame_end, got.frame_end);
      compare("status", want.status, got.status);
      compare("plain_text_flag", want.plain_text_flag, got.plain_text_flag);
      compare("eos_clean", want.eos_clean, got.eos_clean);
      compare("frame_length", want.frame_length, got.frame_length);
    endfunction
  endclass

  frame_scoreboard sb;
  int unsigned     src_idle_pct;
  int unsigned     sink_stall_pct;
  bit              hold_req;
  int unsigned     bytes_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: check each transfer, then decide on ready for the next edge
  initial begin
    nfrc_pkg::result_t got;
    int                hold_left;
    hold_left  = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
        got.data_byte       = out_tdata[7:0];
        got.frame_length    = out_tdata[24:8];
        got.frame_end       = out_tlast;
        got.status          = nfrc_pkg::status_t'(out_tuser[1:0]);
        got.plain_text_flag = out_tuser[2];
        got.eos_clean       = out_tuser[3];
        sb.check_result(got);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst_n !== 1'b1 || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_item(input logic [1:0] k, input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(k, b);
    if (k != nfrc_pkg::KIND_NONE) bytes_sent++;
  endtask

  task automatic write_limit(input logic [16:0] v);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_limit(v);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_item(nfrc_pkg::KIND_DATA, s[i]);
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(nfrc_pkg::PRINT_HI, nfrc_pkg::PRINT_LO));
    if (b == nfrc_pkg::CH_LBRACE) b = "x";
    return b;
  endfunction

  // one frame: mostly well formed, with random content and ending
  task automatic send_frame();
    int unsigned shape;
    int unsigned len;
    int unsigned ending;
    int          i;
    logic [7:0]  b;
    shape = $urandom_range(9);
    len   = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(10);
    for (i = 0; i < len; i++) begin
      case (shape)
        0, 1, 2, 3: b = (i == 0) ? nfrc_pkg::CH_LBRACE :
                        8'($urandom_range(nfrc_pkg::PRINT_HI, nfrc_pkg::PRINT_LO));
        4:          b = text_byte();
        5:          b = (i == 0) ? nfrc_pkg::CH_SPACE :
                        (i == 1) ? nfrc_pkg::CH_TAB : text_byte();
        6:          b = $urandom_range(1) ? nfrc_pkg::CH_SPACE : nfrc_pkg::CH_TAB;
        7: begin
          b = 8'($urandom_range(255));
          if (b == nfrc_pkg::CH_LF) b = 8'h0B;
        end
        default:    b = 8'($urandom_range(255));
      endcase
      send_item(nfrc_pkg::KIND_DATA, b);
      if ($urandom_range(19) == 0) send_item(nfrc_pkg::KIND_NONE, 8'($urandom_range(255)));
    end
    ending = $urandom_range(19);
    if (ending < 15)       send_item(nfrc_pkg::KIND_DATA, nfrc_pkg::CH_LF);
    else if (ending < 17)  send_item(nfrc_pkg::KIND_EOS, 8'($urandom_range(255)));
    else if (ending == 17) send_item(nfrc_pkg::KIND_ERR, 8'($urandom_range(255)));
    else if (ending == 18) begin
      send_item(nfrc_pkg::KIND_DATA, nfrc_pkg::CH_CR);
      send_text("rest");
      send_item(nfrc_pkg::KIND_DATA, nfrc_pkg::CH_LF);
    end
  endtask

  initial begin
    logic [16:0] limit_tab [7] = '{17'd65536, 17'd1, 17'd4, 17'd0, 17'd131071, 17'd16,
                                   17'd65536};
    int unsigned src_tab   [7] = '{0, 61, 0, 7, 0, 7, 0};
    int unsigned sink_tab  [7] = '{0, 0, 61, 7, 0, 7, 0};
    int unsigned count_tab [7] = '{400, 300, 300, 100, 100, 300, 300};
    int unsigned phase_end;
    int          p;
    int          i;

    sb             = new();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_req       = 1'b0;
    bytes_sent     = 0;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= nfrc_pkg::KIND_DATA;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    phase_end = 0;
    for (p = 0; p < 7; p++) begin
      write_limit(limit_tab[p]);
      src_idle_pct   = src_tab[p];
      sink_stall_pct = sink_tab[p];
      phase_end += count_tab[p];
      if (p == 0) begin
        send_text("{\"}");
        send_item(nfrc_pkg::KIND_DATA, nfrc_pkg::CH_LF);     // well-formed object
        send_item(nfrc_pkg::KIND_DATA, nfrc_pkg::CH_LF);     // empty line
        send_text(" \tab");
        send_item(nfrc_pkg::KIND_DATA, nfrc_pkg::CH_LF);     // plain text after whitespace
        send_item(nfrc_pkg::KIND_DATA, nfrc_pkg::CH_LBRACE);
        send_item(nfrc_pkg::KIND_DATA, 8'hFF);
        send_item(nfrc_pkg::KIND_DATA, 8'h00);
        send_item(nfrc_pkg::KIND_DATA, nfrc_pkg::CH_LF);     // binary, not text
        send_text("x");
        send_item(nfrc_pkg::KIND_DATA, nfrc_pkg::CH_CR);     // CR, then line dropped
        send_text("y");
        send_item(nfrc_pkg::KIND_DATA, nfrc_pkg::CH_LF);
        send_text("a");
        send_item(nfrc_pkg::KIND_EOS, 8'h00);                // truncated by end of stream
        send_item(nfrc_pkg::KIND_EOS, 8'hFF);                // clean end of stream
        send_text("z");
        send_item(nfrc_pkg::KIND_ERR, 8'h5A);                // read error
        send_item(nfrc_pkg::KIND_NONE, 8'hA5);               // ignored kind
        hold_req = 1'b1;
      end
      while (bytes_sent < phase_end) begin
        if ($urandom_range(9) == 0)
          send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
        else
          send_frame();
      end
    end

    // frame exactly at the limit, then overflow and resync
    write_limit(17'(FINAL_LIMIT));
    send_item(nfrc_pkg::KIND_DATA, nfrc_pkg::CH_LBRACE);
    for (i = 1; i < FINAL_LIMIT; i++) send_item(nfrc_pkg::KIND_DATA, "a");
    send_item(nfrc_pkg::KIND_DATA, "a");
    send_text("bc");
    send_item(nfrc_pkg::KIND_DATA, nfrc_pkg::CH_LF);
    send_item(nfrc_pkg::KIND_EOS, 8'h00);

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
